[hw/rtl/battery_charge_test_supervisor_assert.svh]
`ifndef BATTERY_CHARGE_TEST_SUPERVISOR_ASSERT_SVH
`define BATTERY_CHARGE_TEST_SUPERVISOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BCTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcts check failed");

// next-cycle implication, sampled on clk, off while in reset
`define BCTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcts check failed");

`endif

[hw/rtl/bcts_pkg.sv]
`default_nettype none

package bcts_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_PRESENT_MV      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ON_PHASE_TICKS       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_PHASE_TICKS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARGING_CLEAR_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_SET_MV         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_CLEAR_MV       = 3'd5;

    localparam logic [15:0] RST_LINE_PRESENT_MV      = 16'd18000;
    localparam logic [15:0] RST_ON_PHASE_TICKS       = 16'd30000;
    localparam logic [15:0] RST_OFF_PHASE_TICKS      = 16'd5000;
    localparam logic [15:0] RST_CHARGING_CLEAR_TICKS = 16'd2000;
    localparam logic [15:0] RST_FAULT_SET_MV         = 16'd8000;
    localparam logic [15:0] RST_FAULT_CLEAR_MV       = 16'd10000;

    localparam logic [1:0] MODE_HOLD = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] line_present_mv;
        logic [15:0] on_phase_ticks;
        logic [15:0] off_phase_ticks;
        logic [15:0] charging_clear_ticks;
        logic [15:0] fault_set_mv;
        logic [15:0] fault_clear_mv;
    } cfg_t;

    typedef struct packed {
        logic [15:0] line_mv;
        logic [15:0] battery_mv;
        logic        charger_charging;
    } tick_t;

    typedef struct packed {
        logic       charger_enable;
        logic       battery_fault;
        logic [1:0] phase;
        logic       sample_taken;
    } result_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bcts_cfg_regs.sv]
`default_nettype none

module bcts_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [bcts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bcts_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bcts_pkg::cfg_t                        cfg
);
    import bcts_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_present_mv      <= RST_LINE_PRESENT_MV;
            cfg_reg.on_phase_ticks       <= RST_ON_PHASE_TICKS;
            cfg_reg.off_phase_ticks      <= RST_OFF_PHASE_TICKS;
            cfg_reg.charging_clear_ticks <= RST_CHARGING_CLEAR_TICKS;
            cfg_reg.fault_set_mv         <= RST_FAULT_SET_MV;
            cfg_reg.fault_clear_mv       <= RST_FAULT_CLEAR_MV;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_LINE_PRESENT_MV:      cfg_reg.line_present_mv      <= cfg_data;
                CFG_ON_PHASE_TICKS:       cfg_reg.on_phase_ticks       <= cfg_data;
                CFG_OFF_PHASE_TICKS:      cfg_reg.off_phase_ticks      <= cfg_data;
                CFG_CHARGING_CLEAR_TICKS: cfg_reg.charging_clear_ticks <= cfg_data;
                CFG_FAULT_SET_MV:         cfg_reg.fault_set_mv         <= cfg_data;
                CFG_FAULT_CLEAR_MV:       cfg_reg.fault_clear_mv       <= cfg_data;
                default:                  ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hw/rtl/bcts_step.sv]
`default_nettype none

module bcts_step (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire bcts_pkg::tick_t  tick,
    input  wire bcts_pkg::cfg_t   cfg,
    output bcts_pkg::result_t     result
);
    import bcts_pkg::*;

    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;
    logic [15:0] phase_elapsed_reg;
    logic [15:0] phase_elapsed_next;
    logic [15:0] hold_elapsed_reg;
    logic [15:0] hold_elapsed_next;
    logic        hold_running_reg;
    logic        hold_running_next;
    logic        fault_reg;
    logic        fault_next;
    logic        line_ok;
    logic        enable;
    logic        sampled;

    always_comb
    begin
        line_ok            = tick.line_mv >= cfg.line_present_mv;
        mode_next          = mode_reg;
        phase_elapsed_next = sat_inc(phase_elapsed_reg);
        hold_elapsed_next  = hold_elapsed_reg;
        hold_running_next  = hold_running_reg;
        fault_next         = fault_reg;
        enable             = 1'b0;
        sampled            = 1'b0;

        if (mode_reg != MODE_OFF && line_ok && tick.charger_charging)
        begin
            // charging in hold
            enable = 1'b1;
            if (!hold_running_reg)
            begin
                hold_running_next = 1'b1;
                hold_elapsed_next = 16'd0;
            end
            else
            begin
                hold_elapsed_next = sat_inc(hold_elapsed_reg);
            end
            if (hold_elapsed_next >= cfg.charging_clear_ticks)
            begin
                fault_next = 1'b0;
            end
            if (mode_reg != MODE_HOLD)
            begin
                mode_next          = MODE_HOLD;
                phase_elapsed_next = 16'd0;
            end
        end
        else
        begin
            hold_running_next = 1'b0;
            hold_elapsed_next = 16'd0;
            if (mode_reg == MODE_HOLD)
            begin
                mode_next          = MODE_ON;
                phase_elapsed_next = 16'd0;
            end
            if (mode_next == MODE_OFF)
            begin
                // end of off phase: battery sample
                if (phase_elapsed_next >= cfg.off_phase_ticks)
                begin
                    if (tick.battery_mv < cfg.fault_set_mv)
                    begin
                        fault_next = 1'b1;
                    end
                    else if (tick.battery_mv > cfg.fault_clear_mv)
                    begin
                        fault_next = 1'b0;
                    end
                    sampled            = 1'b1;
                    mode_next          = MODE_ON;
                    phase_elapsed_next = 16'd0;
                end
            end
            else
            begin
                enable = 1'b1;
                if (phase_elapsed_next >= cfg.on_phase_ticks)
                begin
                    mode_next          = MODE_OFF;
                    phase_elapsed_next = 16'd0;
                end
            end
        end

        result.charger_enable = enable;
        result.battery_fault  = fault_next;
        result.phase          = mode_next;
        result.sample_taken   = sampled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_HOLD;
            phase_elapsed_reg <= 16'd0;
            hold_elapsed_reg  <= 16'd0;
            hold_running_reg  <= 1'b0;
            fault_reg         <= 1'b0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            phase_elapsed_reg <= phase_elapsed_next;
            hold_elapsed_reg  <= hold_elapsed_next;
            hold_running_reg  <= hold_running_next;
            fault_reg         <= fault_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/battery_charge_test_supervisor.sv]
// a tick passes the tick register, then the result register, before its result is offered
// throughput: one tick per cycle while results are taken, set by the single state update done per cycle
// a stalled result does not block a new tick until the tick register is also full
// reset (rst_n low, asynchronous): hold mode, counters and fault cleared,
// registers back to their defaults, both stages empty
`default_nettype none

module battery_charge_test_supervisor (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [bcts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bcts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire logic [15:0]                      line_mv,
    input  wire logic [15:0]                      battery_mv,
    input  wire logic                             charger_charging,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output logic                                  charger_enable,
    output logic                                  battery_fault,
    output logic [1:0]                            phase,
    output logic                                  sample_taken
);
    import bcts_pkg::*;

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t step_result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;
    logic    step;

    assign advance    = !result_valid_reg || result_ready;
    assign step       = tick_valid_reg && advance;
    assign item_ready = !tick_valid_reg || advance;

    bcts_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    bcts_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .tick   (tick_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                tick_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= tick_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            tick_reg.line_mv          <= line_mv;
            tick_reg.battery_mv       <= battery_mv;
            tick_reg.charger_charging <= charger_charging;
        end
        if (step)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid   = result_valid_reg;
    assign charger_enable = result_reg.charger_enable;
    assign battery_fault  = result_reg.battery_fault;
    assign phase          = result_reg.phase;
    assign sample_taken   = result_reg.sample_taken;

endmodule

`default_nettype wire

[hw/rtl/bcts_checker.sv]
`default_nettype none

`include "battery_charge_test_supervisor_assert.svh"

module bcts_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       result_valid,
    input  wire logic       result_ready,
    input  wire logic       charger_enable,
    input  wire logic       battery_fault,
    input  wire logic [1:0] phase,
    input  wire logic       sample_taken
);
    import bcts_pkg::*;

    // a sample always ends the off phase with the charger off and returns to on
    `BCTS_ASSERT_NOW(a_sample_to_on, result_valid && sample_taken,
        !charger_enable && phase == MODE_ON)

    // hold keeps the charger on
    `BCTS_ASSERT_NOW(a_hold_enabled, result_valid && phase == MODE_HOLD,
        charger_enable && !sample_taken)

    // on phase without a sample drives the charger
    `BCTS_ASSERT_NOW(a_on_enabled, result_valid && phase == MODE_ON && !sample_taken,
        charger_enable)

    // stalled result holds
    `BCTS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(phase) && $stable(battery_fault)
        && $stable(sample_taken) && $stable(charger_enable))

endmodule

bind battery_charge_test_supervisor bcts_checker u_bcts_checker (.*);

`default_nettype wire

[tb/sv/battery_charge_test_supervisor_tb.sv]
`default_nettype none

module battery_charge_test_supervisor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bcts_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    logic [15:0]            line_mv = '0;
    logic [15:0]            battery_mv = '0;
    logic                   charger_charging = 1'b0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic                   charger_enable;
    logic                   battery_fault;
    logic [1:0]             phase;
    logic                   sample_taken;

    // supervisor state as the testbench tracks it
    cfg_t        sup_cfg = '{line_present_mv: RST_LINE_PRESENT_MV,
                             on_phase_ticks: RST_ON_PHASE_TICKS,
                             off_phase_ticks: RST_OFF_PHASE_TICKS,
                             charging_clear_ticks: RST_CHARGING_CLEAR_TICKS,
                             fault_set_mv: RST_FAULT_SET_MV,
                             fault_clear_mv: RST_FAULT_CLEAR_MV};
    logic [1:0]  sup_mode = MODE_HOLD;
    logic [15:0] phase_ticks = '0;
    logic [15:0] hold_ticks = '0;
    logic        hold_active = 1'b0;
    logic        fault_now = 1'b0;

    result_t     expected_status_q[$];
    int          errors = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    battery_charge_test_supervisor u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .line_mv          (line_mv),
        .battery_mv       (battery_mv),
        .charger_charging (charger_charging),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .charger_enable   (charger_enable),
        .battery_fault    (battery_fault),
        .phase            (phase),
        .sample_taken     (sample_taken)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int clamp16(input int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    function automatic result_t predict_status(input tick_t t);
        result_t r;
        logic    line_ok;
        r = '0;
        line_ok = t.line_mv >= sup_cfg.line_present_mv;
        phase_ticks = (phase_ticks == 16'hFFFF) ? phase_ticks : phase_ticks + 16'd1;
        if (sup_mode != MODE_OFF && line_ok && t.charger_charging)
        begin
            r.charger_enable = 1'b1;
            if (!hold_active)
            begin
                hold_active = 1'b1;
                hold_ticks = '0;
            end
            else
            begin
                hold_ticks = (hold_ticks == 16'hFFFF) ? hold_ticks : hold_ticks + 16'd1;
            end
            if (hold_ticks >= sup_cfg.charging_clear_ticks)
                fault_now = 1'b0;
            if (sup_mode != MODE_HOLD)
            begin
                sup_mode = MODE_HOLD;
                phase_ticks = '0;
            end
        end
        else
        begin
            hold_active = 1'b0;
            hold_ticks = '0;
            if (sup_mode == MODE_HOLD)
            begin
                sup_mode = MODE_ON;
                phase_ticks = '0;
            end
            if (sup_mode == MODE_OFF)
            begin
                if (phase_ticks >= sup_cfg.off_phase_ticks)
                begin
                    if (t.battery_mv < sup_cfg.fault_set_mv)
                        fault_now = 1'b1;
                    else if (t.battery_mv > sup_cfg.fault_clear_mv)
                        fault_now = 1'b0;
                    r.sample_taken = 1'b1;
                    sup_mode = MODE_ON;
                    phase_ticks = '0;
                end
            end
            else
            begin
                r.charger_enable = 1'b1;
                if (phase_ticks >= sup_cfg.on_phase_ticks)
                begin
                    sup_mode = MODE_OFF;
                    phase_ticks = '0;
                end
            end
        end
        r.battery_fault = fault_now;
        r.phase = sup_mode;
        return r;
    endfunction

    // result side: random stalls, checks every transfer against the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got = '{charger_enable: charger_enable, battery_fault: battery_fault,
                        phase: phase, sample_taken: sample_taken};
                if (expected_status_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer: en=%0b fault=%0b phase=%0d smp=%0b",
                                 got.charger_enable, got.battery_fault, got.phase,
                                 got.sample_taken);
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected en=%0b fault=%0b phase=%0d smp=%0b, %s",
                                     want.charger_enable, want.battery_fault, want.phase,
                                     want.sample_taken,
                                     $sformatf("got en=%0b fault=%0b phase=%0d smp=%0b",
                                               got.charger_enable, got.battery_fault,
                                               got.phase, got.sample_taken));
                    end
                end
            end
            if (stall_left != 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    task automatic send_tick(input int line, input int bat, input bit chg);
        tick_t t;
        int    gap;
        t = '{line_mv: line[15:0], battery_mv: bat[15:0], charger_charging: chg};
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        line_mv <= t.line_mv;
        battery_mv <= t.battery_mv;
        charger_charging <= t.charger_charging;
        do
            @(posedge clk);
        while (!item_ready);
        expected_status_q.push_back(predict_status(t));
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        drain();
        write_reg(CFG_LINE_PRESENT_MV, c.line_present_mv);
        write_reg(CFG_ON_PHASE_TICKS, c.on_phase_ticks);
        write_reg(CFG_OFF_PHASE_TICKS, c.off_phase_ticks);
        write_reg(CFG_CHARGING_CLEAR_TICKS, c.charging_clear_ticks);
        write_reg(CFG_FAULT_SET_MV, c.fault_set_mv);
        write_reg(CFG_FAULT_CLEAR_MV, c.fault_clear_mv);
        cfg_write_en <= 1'b0;
        sup_cfg = c;
    endtask

    task automatic test_defaults_and_hold_entry();
        send_tick(65535, 0, 1'b1);
        send_tick(0, 65535, 1'b0);
        send_tick(17999, 12000, 1'b1);
        send_tick(18000, 9000, 1'b1);
        send_tick(30000, 9000, 1'b0);
    endtask

    task automatic test_zero_lengths_and_overlap();
        apply_config('{line_present_mv: 16'hFFFF, on_phase_ticks: 16'd0,
                       off_phase_ticks: 16'd0, charging_clear_ticks: 16'd0,
                       fault_set_mv: 16'hFFFF, fault_clear_mv: 16'd0});
        send_tick(0, 500, 1'b1);
        send_tick(0, 0, 1'b0);
        send_tick(65535, 65535, 1'b1);
        send_tick(65534, 100, 1'b1);
        send_tick(65535, 65535, 1'b1);
        send_tick(65535, 100, 1'b0);
        send_tick(0, 100, 1'b0);
    endtask

    task automatic test_thresholds_and_hold_clear();
        int samples[4] = '{10001, 7999, 10000, 8000};
        apply_config('{line_present_mv: 16'd18000, on_phase_ticks: 16'd1,
                       off_phase_ticks: 16'd2, charging_clear_ticks: 16'd3,
                       fault_set_mv: 16'd8000, fault_clear_mv: 16'd10000});
        foreach (samples[i])
            repeat (3) send_tick(17999, samples[i], 1'b1);
        repeat (2) send_tick(18000, 9000, 1'b1);
        send_tick(17999, 9000, 1'b1);
        repeat (4) send_tick(18000, 9000, 1'b1);
    endtask

    function automatic logic [15:0] rand_ticks();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(1, 12));
    endfunction

    function automatic cfg_t rand_config();
        cfg_t c;
        int   r;
        int   set_mv;
        r = $urandom_range(0, 5);
        c.line_present_mv = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
        c.on_phase_ticks = rand_ticks();
        c.off_phase_ticks = rand_ticks();
        c.charging_clear_ticks = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                           : 16'($urandom_range(0, 8));
        set_mv = $urandom_range(0, 65535);
        c.fault_set_mv = set_mv[15:0];
        if ($urandom_range(0, 3) == 0)
            c.fault_clear_mv = 16'(clamp16(set_mv - $urandom_range(0, 4000)));
        else
            c.fault_clear_mv = 16'(clamp16(set_mv + $urandom_range(0, 4000)));
        return c;
    endfunction

    function automatic int pick_line(input bit present);
        int thr;
        thr = sup_cfg.line_present_mv;
        if (present)
            return ($urandom_range(0, 3) == 0) ? thr : $urandom_range(thr, 65535);
        return ($urandom_range(0, 3) == 0) ? thr - 1 : $urandom_range(0, thr - 1);
    endfunction

    function automatic int pick_battery();
        int set_mv;
        int clr_mv;
        set_mv = sup_cfg.fault_set_mv;
        clr_mv = sup_cfg.fault_clear_mv;
        case ($urandom_range(0, 6))
            0: return clamp16(set_mv - 1);
            1: return set_mv;
            2: return clr_mv;
            3: return clamp16(clr_mv + 1);
            4: return 0;
            5: return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic run_session(input int n);
        int  sent;
        int  kind;
        int  len;
        int  span;
        bit  present;
        sent = 0;
        while (sent < n)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                span = (sup_cfg.charging_clear_ticks > 10) ? 10 : sup_cfg.charging_clear_ticks;
                len = $urandom_range(1, span + 3);
                repeat (len) send_tick(pick_line(1'b1), pick_battery(), 1'b1);
            end
            else if (kind < 8)
            begin
                span = sup_cfg.on_phase_ticks + sup_cfg.off_phase_ticks;
                len = $urandom_range(1, ((span > 20) ? 20 : span) + 3);
                repeat (len)
                begin
                    present = (sup_cfg.line_present_mv == 16'd0) || $urandom_range(0, 1);
                    if (present)
                        send_tick(pick_line(1'b1), pick_battery(), 1'b0);
                    else
                        send_tick(pick_line(1'b0), pick_battery(), 1'($urandom_range(0, 1)));
                end
            end
            else
            begin
                len = 1;
                send_tick($urandom_range(0, 65535), $urandom_range(0, 65535),
                          1'($urandom_range(0, 1)));
            end
            sent += len;
        end
    endtask

    task automatic test_random_sessions();
        for (int s = 0; s < 12; s++)
        begin
            apply_config(rand_config());
            calm = (s % 4 == 3);
            run_session(50);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults_and_hold_entry();
        test_zero_lengths_and_overlap();
        test_thresholds_and_hold_clear();
        test_random_sessions();
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("[battery_charge_test_supervisor] OK");
        else
            $display("[battery_charge_test_supervisor] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[battery_charge_test_supervisor] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/bcts_pkg.sv
hw/rtl/bcts_cfg_regs.sv
hw/rtl/bcts_step.sv
hw/rtl/battery_charge_test_supervisor.sv
hw/rtl/bcts_checker.sv
tb/sv/battery_charge_test_supervisor_tb.sv
